>>> hw/rtl/ubxp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UBX frame parser package
// Sync bytes, class and id codes, parser phase codes, status codes and the
// verdict record passed from the frame judge to the parser.
// ----------------------------------------------------------------------------
package ubxp_pkg;

  localparam logic [7:0] SYNC_FIRST  = 8'hB5;
  localparam logic [7:0] SYNC_SECOND = 8'h62;
  localparam logic [7:0] CLS_NAV     = 8'h01;
  localparam logic [7:0] ID_PVT      = 8'h07;
  localparam logic [7:0] ID_DOP      = 8'h04;
  localparam logic [7:0] CLS_ACK     = 8'h05;
  localparam logic [7:0] ID_ACK      = 8'h01;
  localparam logic [7:0] CLS_MON     = 8'h0A;
  localparam logic [7:0] ID_VER      = 8'h04;

  localparam logic [15:0] ACK_MIN_LENGTH = 16'd2;

  localparam int STATE_W = 4;
  typedef logic [STATE_W-1:0] state_t;

  localparam state_t ST_HUNT    = 4'd0;
  localparam state_t ST_SYNC2   = 4'd1;
  localparam state_t ST_CLASS   = 4'd2;
  localparam state_t ST_ID      = 4'd3;
  localparam state_t ST_LEN_LO  = 4'd4;
  localparam state_t ST_LEN_HI  = 4'd5;
  localparam state_t ST_PAYLOAD = 4'd6;
  localparam state_t ST_CK_A    = 4'd7;
  localparam state_t ST_CK_B    = 4'd8;

  typedef logic [2:0] status_t;

  localparam status_t RES_BUSY  = 3'd0;
  localparam status_t RES_ERROR = 3'd1;
  localparam status_t RES_PVT   = 3'd2;
  localparam status_t RES_DOP   = 3'd3;
  localparam status_t RES_ACK   = 3'd4;
  localparam status_t RES_NAK   = 3'd5;
  localparam status_t RES_VER   = 3'd6;
  localparam status_t RES_OTHER = 3'd7;

  typedef struct packed {
    status_t status;
    logic    pvt_hit;
    logic    ack_hit;
  } verdict_t;

endpackage

>>> hw/rtl/ubx_frame_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UBX frame parser
// Byte-wide UBX receiver: sync hunt, header, payload, 8-bit Fletcher check,
// and one status transfer per received byte.
//
//   channel | ports                              | direction
//   --------+------------------------------------+----------
//   in      | in_valid, in_stall, in_rx_byte     | byte in
//   out     | out_valid, out_stall, out_status,  | status out
//           | out_frame_class, out_frame_id,     |
//           | out_frame_length, out_acked_class, |
//           | out_acked_id, out_pvt_seen         |
//
// One byte per cycle while in_stall is low; each result shows the next cycle.
// The output register holds one result; in_stall rises only while that result
// waits under out_stall. Reset returns the parser to the sync hunt with all
// frame fields cleared except the two stored payload bytes. Only the first
// two payload bytes are kept, for the ACK/NAK capture.
// ----------------------------------------------------------------------------
module ubx_frame_parser #(
  parameter int PAYLOAD_DEPTH = 256,
  parameter int PVT_LENGTH    = 92,
  parameter int DOP_LENGTH    = 18
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_status,
  output logic [7:0]  out_frame_class,
  output logic [7:0]  out_frame_id,
  output logic [15:0] out_frame_length,
  output logic [7:0]  out_acked_class,
  output logic [7:0]  out_acked_id,
  output logic        out_pvt_seen
);
  import ubxp_pkg::*;

  localparam int          IDX_W     = $clog2(PAYLOAD_DEPTH + 1);
  localparam logic [16:0] DEPTH_LIM = 17'(PAYLOAD_DEPTH);

  state_t      state_r, state_nxt;
  logic [7:0]  sum_a_r, sum_a_nxt;
  logic [7:0]  sum_b_r, sum_b_nxt;
  logic [7:0]  rx_sum_a_r, rx_sum_a_nxt;
  logic [7:0]  class_r, class_nxt;
  logic [7:0]  id_r, id_nxt;
  logic [15:0] length_r, length_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic [7:0]  pay0_r, pay0_nxt;
  logic [7:0]  pay1_r, pay1_nxt;
  logic [7:0]  ack_class_r, ack_class_nxt;
  logic [7:0]  ack_id_r, ack_id_nxt;
  logic        pvt_r, pvt_nxt;
  status_t     status_r, status_nxt;
  logic        out_valid_r, out_valid_nxt;

  logic        in_xfer;
  logic [7:0]  b;
  logic [7:0]  add_a;
  logic [7:0]  add_b;
  logic [15:0] len_full;
  logic [IDX_W-1:0] idx_inc;
  verdict_t    verdict;

  ubxp_judge #(
    .PVT_LENGTH(PVT_LENGTH),
    .DOP_LENGTH(DOP_LENGTH)
  ) u_judge (
    .frame_class (class_r),
    .frame_id    (id_r),
    .frame_length(length_r),
    .verdict     (verdict)
  );

  assign in_stall = out_valid_r & out_stall;
  assign in_xfer  = in_valid & ~in_stall;
  assign b        = in_rx_byte;
  assign add_a    = sum_a_r + b;
  assign add_b    = sum_b_r + add_a;
  assign len_full = {b, length_r[7:0]};
  assign idx_inc  = idx_r + IDX_W'(1);

  always_comb begin
    state_nxt     = state_r;
    sum_a_nxt     = sum_a_r;
    sum_b_nxt     = sum_b_r;
    rx_sum_a_nxt  = rx_sum_a_r;
    class_nxt     = class_r;
    id_nxt        = id_r;
    length_nxt    = length_r;
    idx_nxt       = idx_r;
    pay0_nxt      = pay0_r;
    pay1_nxt      = pay1_r;
    ack_class_nxt = ack_class_r;
    ack_id_nxt    = ack_id_r;
    pvt_nxt       = pvt_r;
    status_nxt    = status_r;
    out_valid_nxt = out_valid_r & out_stall;
    if (in_xfer) begin
      out_valid_nxt = 1'b1;
      status_nxt    = RES_BUSY;
      case (state_r)
        ST_HUNT: begin
          if (b == SYNC_FIRST) state_nxt = ST_SYNC2;
        end
        ST_SYNC2: begin
          if (b == SYNC_SECOND) begin
            state_nxt = ST_CLASS;
            sum_a_nxt = 8'd0;
            sum_b_nxt = 8'd0;
          end else if (b != SYNC_FIRST) begin
            state_nxt = ST_HUNT;
          end
        end
        ST_CLASS: begin
          class_nxt = b;
          sum_a_nxt = add_a;
          sum_b_nxt = add_b;
          state_nxt = ST_ID;
        end
        ST_ID: begin
          id_nxt    = b;
          sum_a_nxt = add_a;
          sum_b_nxt = add_b;
          state_nxt = ST_LEN_LO;
        end
        ST_LEN_LO: begin
          length_nxt = {8'd0, b};
          sum_a_nxt  = add_a;
          sum_b_nxt  = add_b;
          state_nxt  = ST_LEN_HI;
        end
        ST_LEN_HI: begin
          length_nxt = len_full;
          sum_a_nxt  = add_a;
          sum_b_nxt  = add_b;
          idx_nxt    = '0;
          if ({1'b0, len_full} > DEPTH_LIM) begin
            state_nxt  = ST_HUNT;
            status_nxt = RES_ERROR;
          end else if (len_full == 16'd0) begin
            state_nxt = ST_CK_A;
          end else begin
            state_nxt = ST_PAYLOAD;
          end
        end
        ST_PAYLOAD: begin
          if (idx_r == IDX_W'(0)) pay0_nxt = b;
          if (idx_r == IDX_W'(1)) pay1_nxt = b;
          idx_nxt   = idx_inc;
          sum_a_nxt = add_a;
          sum_b_nxt = add_b;
          if (17'(idx_inc) >= {1'b0, length_r}) state_nxt = ST_CK_A;
        end
        ST_CK_A: begin
          rx_sum_a_nxt = b;
          state_nxt    = ST_CK_B;
        end
        ST_CK_B: begin
          state_nxt = ST_HUNT;
          if (sum_a_r != rx_sum_a_r || sum_b_r != b) begin
            status_nxt = RES_ERROR;
          end else begin
            status_nxt = verdict.status;
            if (verdict.pvt_hit) pvt_nxt = 1'b1;
            if (verdict.ack_hit) begin
              ack_class_nxt = pay0_r;
              ack_id_nxt    = pay1_r;
            end
          end
        end
        default: begin
          state_nxt = ST_HUNT;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_HUNT;
      sum_a_r     <= 8'd0;
      sum_b_r     <= 8'd0;
      rx_sum_a_r  <= 8'd0;
      class_r     <= 8'd0;
      id_r        <= 8'd0;
      length_r    <= 16'd0;
      idx_r       <= '0;
      ack_class_r <= 8'd0;
      ack_id_r    <= 8'd0;
      pvt_r       <= 1'b0;
      status_r    <= RES_BUSY;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sum_a_r     <= sum_a_nxt;
      sum_b_r     <= sum_b_nxt;
      rx_sum_a_r  <= rx_sum_a_nxt;
      class_r     <= class_nxt;
      id_r        <= id_nxt;
      length_r    <= length_nxt;
      idx_r       <= idx_nxt;
      ack_class_r <= ack_class_nxt;
      ack_id_r    <= ack_id_nxt;
      pvt_r       <= pvt_nxt;
      status_r    <= status_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pay0_r <= pay0_nxt;
    pay1_r <= pay1_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_status       = status_r;
  assign out_frame_class  = class_r;
  assign out_frame_id     = id_r;
  assign out_frame_length = length_r;
  assign out_acked_class  = ack_class_r;
  assign out_acked_id     = ack_id_r;
  assign out_pvt_seen     = pvt_r;

endmodule

>>> hw/rtl/ubxp_judge.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UBX frame judge
// Classifies a frame with a good checksum by class, id and length, and flags
// the PVT and ACK/NAK captures.
// ----------------------------------------------------------------------------
module ubxp_judge #(
  parameter int PVT_LENGTH = 92,
  parameter int DOP_LENGTH = 18
) (
  input  logic [7:0]        frame_class,
  input  logic [7:0]        frame_id,
  input  logic [15:0]       frame_length,
  output ubxp_pkg::verdict_t verdict
);
  import ubxp_pkg::*;

  localparam logic [16:0] PVT_MIN = 17'(PVT_LENGTH);
  localparam logic [16:0] DOP_MIN = 17'(DOP_LENGTH);

  logic [16:0] len_ext;

  assign len_ext = {1'b0, frame_length};

  always_comb begin
    verdict.status  = RES_OTHER;
    verdict.pvt_hit = 1'b0;
    verdict.ack_hit = 1'b0;
    if (frame_class == CLS_NAV && frame_id == ID_PVT) begin
      if (len_ext >= PVT_MIN) begin
        verdict.status  = RES_PVT;
        verdict.pvt_hit = 1'b1;
      end
    end else if (frame_class == CLS_NAV && frame_id == ID_DOP) begin
      if (len_ext >= DOP_MIN) begin
        verdict.status = RES_DOP;
      end
    end else if (frame_class == CLS_ACK) begin
      if (frame_length >= ACK_MIN_LENGTH) begin
        verdict.status  = (frame_id == ID_ACK) ? RES_ACK : RES_NAK;
        verdict.ack_hit = 1'b1;
      end
    end else if (frame_class == CLS_MON && frame_id == ID_VER) begin
      verdict.status = RES_VER;
    end
  end

endmodule
